// ===== design/lzwc_pkg.sv =====
package lzwc_pkg;

    localparam int unsigned DICT_LIMIT = 65535;
    localparam int unsigned FIRST_FREE = 256;

    // Hash table of dictionary entries, linear probing
    localparam int unsigned SLOT_BITS  = 17;
    localparam int unsigned EPOCH_BITS = 8;
    localparam logic [EPOCH_BITS-1:0] EPOCH_MAX = '1;

    // Output queue
    localparam int unsigned Q_DEPTH   = 4;
    localparam int unsigned QPTR_BITS = $clog2(Q_DEPTH);
    localparam int unsigned QCNT_BITS = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic [EPOCH_BITS-1:0] epoch;
        logic [15:0]           key_code;
        logic [7:0]            key_byte;
        logic [15:0]           child;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [15:0] code;
        logic        item_last;
        logic        stream_end;
    } t_res;

    typedef struct packed {
        logic [1:0] n;
        t_res       res0;
        t_res       res1;
    } t_push;

    function automatic logic [SLOT_BITS-1:0] slot_hash(input logic [15:0] code,
                                                       input logic [7:0]  data);
        return {data, code[8:0]} ^ {10'd0, code[15:9]};
    endfunction

endpackage

// ===== design/lzwc_ram.sv =====
module lzwc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 131072
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-first on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== design/lzwc_ctrl.sv =====
module lzwc_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_stream_last,
    input  logic [lzwc_pkg::QCNT_BITS-1:0]    i_free,
    output lzwc_pkg::t_push                   o_push,
    output logic                              o_rd_en,
    output logic [lzwc_pkg::SLOT_BITS-1:0]    o_rd_addr,
    input  lzwc_pkg::t_entry                  i_rd_data,
    output logic                              o_wr_en,
    output logic [lzwc_pkg::SLOT_BITS-1:0]    o_wr_addr,
    output lzwc_pkg::t_entry                  o_wr_data
);
    import lzwc_pkg::*;

    t_state                r_state, n_state;
    logic [SLOT_BITS-1:0]  r_clr_addr, n_clr_addr;
    logic [15:0]           r_match, n_match;
    logic                  r_match_valid, n_match_valid;
    logic [15:0]           r_next_code, n_next_code;
    logic [EPOCH_BITS-1:0] r_epoch, n_epoch;
    logic [7:0]            r_byte, n_byte;
    logic                  r_last, n_last;
    logic [SLOT_BITS-1:0]  r_addr, n_addr;
    logic                  r_fwd, n_fwd;
    t_entry                r_fwd_data, n_fwd_data;

    t_entry                rd;
    logic                  live, hit, miss, bump, wrap;
    logic [1:0]            need;
    logic [15:0]           nm;
    logic [16:0]           sum;
    logic [SLOT_BITS-1:0]  h_idle, h_next;

    // entry just written wins over the stale RAM word
    assign rd   = r_fwd ? r_fwd_data : i_rd_data;
    assign live = (rd.epoch == r_epoch);
    assign hit  = live && (rd.key_code == r_match) && (rd.key_byte == r_byte);
    assign miss = !live;
    assign need = miss ? (r_last ? 2'd2 : 2'd1) : (r_last ? 2'd1 : 2'd0);
    assign sum  = {1'b0, r_next_code} + 17'd1;
    assign nm   = miss ? {8'd0, r_byte} : rd.child;
    assign wrap = (r_epoch == EPOCH_MAX);

    assign h_idle = slot_hash(r_match, i_data_byte);
    assign h_next = slot_hash(nm, i_data_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_clr_addr    <= '0;
            r_match       <= '0;
            r_match_valid <= 1'b0;
            r_next_code   <= 16'(FIRST_FREE);
            r_epoch       <= EPOCH_BITS'(1);
            r_fwd         <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_clr_addr    <= n_clr_addr;
            r_match       <= n_match;
            r_match_valid <= n_match_valid;
            r_next_code   <= n_next_code;
            r_epoch       <= n_epoch;
            r_fwd         <= n_fwd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_last     <= n_last;
        r_addr     <= n_addr;
        r_fwd_data <= n_fwd_data;
    end

    always_comb begin
        n_state       = r_state;
        n_clr_addr    = r_clr_addr;
        n_match       = r_match;
        n_match_valid = r_match_valid;
        n_next_code   = r_next_code;
        n_epoch       = r_epoch;
        n_byte        = r_byte;
        n_last        = r_last;
        n_addr        = r_addr;
        n_fwd         = r_fwd;
        n_fwd_data    = r_fwd_data;
        bump          = 1'b0;
        o_ready       = 1'b0;
        o_push        = '0;
        o_rd_en       = 1'b0;
        o_rd_addr     = r_addr;
        o_wr_en       = 1'b0;
        o_wr_addr     = r_addr;
        o_wr_data     = '{epoch: r_epoch, key_code: r_match, key_byte: r_byte,
                          child: r_next_code};

        unique case (r_state)
            ST_CLEAR: begin
                o_wr_en    = 1'b1;
                o_wr_addr  = r_clr_addr;
                o_wr_data  = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (!r_match_valid) begin
                    // first byte of a stream: no lookup
                    o_ready = (i_free != '0);
                    if (i_valid && o_ready) begin
                        if (i_stream_last) begin
                            o_push.n    = 2'd1;
                            o_push.res0 = '{code: {8'd0, i_data_byte}, item_last: 1'b1,
                                            stream_end: 1'b1};
                        end else begin
                            n_match       = {8'd0, i_data_byte};
                            n_match_valid = 1'b1;
                        end
                    end
                end else begin
                    o_ready = 1'b1;
                    if (i_valid) begin
                        n_byte    = i_data_byte;
                        n_last    = i_stream_last;
                        n_addr    = h_idle;
                        o_rd_en   = 1'b1;
                        o_rd_addr = h_idle;
                        n_fwd     = 1'b0;
                        n_state   = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP: begin
                if (!hit && !miss) begin
                    // occupied by another key: next slot
                    n_addr    = r_addr + 1'b1;
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_addr + 1'b1;
                    n_fwd     = 1'b0;
                end else if (i_free >= {1'b0, need}) begin
                    bump = r_last;
                    if (miss) begin
                        o_wr_en     = 1'b1;
                        o_push.n    = 2'd1;
                        o_push.res0 = '{code: r_match, item_last: !r_last, stream_end: 1'b0};
                        if (sum >= 17'(DICT_LIMIT)) begin
                            bump        = 1'b1;
                            n_next_code = 16'(FIRST_FREE);
                        end else begin
                            n_next_code = sum[15:0];
                        end
                    end
                    if (r_last) begin
                        if (miss) begin
                            o_push.n    = 2'd2;
                            o_push.res1 = '{code: nm, item_last: 1'b1, stream_end: 1'b1};
                        end else begin
                            o_push.n    = 2'd1;
                            o_push.res0 = '{code: nm, item_last: 1'b1, stream_end: 1'b1};
                        end
                        n_match       = '0;
                        n_match_valid = 1'b0;
                        n_next_code   = 16'(FIRST_FREE);
                    end else begin
                        n_match = nm;
                    end

                    n_fwd   = 1'b0;
                    n_state = ST_IDLE;
                    if (bump) begin
                        if (wrap) begin
                            n_epoch = EPOCH_BITS'(1);
                            n_state = ST_CLEAR;
                        end else begin
                            n_epoch = r_epoch + 1'b1;
                        end
                    end

                    // next byte chains straight onto the resolved match
                    if (!(bump && wrap) && !r_last) begin
                        o_ready = 1'b1;
                        if (i_valid) begin
                            n_byte     = i_data_byte;
                            n_last     = i_stream_last;
                            n_addr     = h_next;
                            o_rd_en    = 1'b1;
                            o_rd_addr  = h_next;
                            n_fwd      = miss && (h_next == r_addr);
                            n_fwd_data = o_wr_data;
                            n_state    = ST_LOOKUP;
                        end
                    end
                end
            end

            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_ready)
        else $error("input accepted during dictionary clearing pass");

    a_match_below_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_match_valid && (r_match >= 16'(FIRST_FREE))) |-> (r_match < r_next_code))
        else $error("match code not yet assigned in dictionary");

    a_stream_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_push.n != 2'd0) && (o_push.res0.stream_end || o_push.res1.stream_end))
        |=> !r_match_valid)
        else $error("match still valid after stream end");
`endif

endmodule

// ===== design/lzwc_outq.sv =====
module lzwc_outq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lzwc_pkg::t_push                i_push,
    output logic [lzwc_pkg::QCNT_BITS-1:0] o_free,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [15:0]                    o_code,
    output logic                           o_item_last,
    output logic                           o_stream_end
);
    import lzwc_pkg::*;

    t_res                 r_q [Q_DEPTH];
    logic [QPTR_BITS-1:0] r_head, n_head;
    logic [QPTR_BITS-1:0] r_tail, n_tail;
    logic [QCNT_BITS-1:0] r_cnt, n_cnt;
    logic                 pop;

    assign o_valid      = (r_cnt != '0);
    assign pop          = o_valid && i_ready;
    assign o_free       = QCNT_BITS'(Q_DEPTH) - r_cnt;
    assign o_code       = r_q[r_head].code;
    assign o_item_last  = r_q[r_head].item_last;
    assign o_stream_end = r_q[r_head].stream_end;

    always_comb begin
        n_head = r_head + QPTR_BITS'(pop);
        n_tail = r_tail + QPTR_BITS'(i_push.n);
        n_cnt  = r_cnt + QCNT_BITS'(i_push.n) - QCNT_BITS'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_q[r_tail] <= i_push.res0;
        end
        if (i_push.n == 2'd2) begin
            r_q[r_tail + 1'b1] <= i_push.res1;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (QCNT_BITS'(i_push.n) <= o_free))
        else $error("output queue overflow");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= QCNT_BITS'(Q_DEPTH)))
        else $error("output queue count out of range");
`endif

endmodule

// ===== design/lzw_compressor_16bit.sv =====
// LZW compressor, one byte per input beat, fixed 16-bit output codes. The
// dictionary is a 128K-entry hash table in one simple dual-port RAM, searched
// by linear probing; a per-entry epoch tag marks entries of earlier
// dictionaries as empty. Once a byte's lookup hits or finds an empty slot
// and the output queue has room, the next byte is taken in that same cycle;
// each slot held by another key adds a probe. After a stream-end byte the
// next byte is taken only from the idle state. A clearing pass over all
// 131072 RAM slots runs after reset and after every 255th dictionary clear
// (dictionary full, or end of a stream of two or more bytes), taking no
// input. Results go through a 4-beat output queue, up to two per input byte.
module lzw_compressor_16bit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_stream_last,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_code,
    output logic        o_item_last,
    output logic        o_stream_end
);
    import lzwc_pkg::*;

    t_push                push;
    logic [QCNT_BITS-1:0] free;
    logic                 rd_en, wr_en;
    logic [SLOT_BITS-1:0] rd_addr, wr_addr;
    t_entry               rd_data, wr_data;

    lzwc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_stream_last (i_stream_last),
        .i_free        (free),
        .o_push        (push),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data)
    );

    lzwc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (1 << SLOT_BITS)
    ) u_dict (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lzwc_outq u_outq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_free       (free),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_code       (o_code),
        .o_item_last  (o_item_last),
        .o_stream_end (o_stream_end)
    );

endmodule

// ===== verif/lzw_compressor_16bit_test.sv =====
`timescale 1ns / 100ps

module lzw_compressor_16bit_test;
    import lzwc_pkg::*;

    // longest legal silence is the RAM clearing pass
    localparam int unsigned QUIET_LIMIT = 400000;
    localparam int unsigned PRINT_CAP   = 50;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte = '0;
    logic        i_stream_last = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_code;
    logic        o_item_last;
    logic        o_stream_end;

    lzw_compressor_16bit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_data_byte   (i_data_byte),
        .i_stream_last (i_stream_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_code        (o_code),
        .o_item_last   (o_item_last),
        .o_stream_end  (o_stream_end)
    );

    // encoder state mirrored in the bench
    logic [15:0] cur_match;
    logic        cur_match_valid;
    int unsigned next_code;
    logic [15:0] dict_child [logic [23:0]];
    t_res        pending_codes [$];

    int error_count  = 0;
    int in_hold_max  = 0;
    int out_hold_max = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_error(input string msg);
        if (error_count < PRINT_CAP)
            $display("ERROR @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void dict_restart();
        dict_child.delete();
        next_code = FIRST_FREE;
    endfunction

    function automatic void stream_restart();
        cur_match       = '0;
        cur_match_valid = 1'b0;
        dict_restart();
    endfunction

    // Advance the encoder by one byte and queue the codes it emits.
    function automatic void lzw_encode_byte(input logic [7:0] data, input logic is_last);
        logic [23:0] key;
        key = {cur_match, data};
        if (!cur_match_valid) begin
            cur_match       = {8'd0, data};
            cur_match_valid = 1'b1;
        end else if (dict_child.exists(key)) begin
            cur_match = dict_child[key];
        end else begin
            dict_child[key] = next_code[15:0];
            pending_codes.push_back('{code: cur_match, item_last: !is_last, stream_end: 1'b0});
            next_code++;
            if (next_code >= DICT_LIMIT)
                dict_restart();
            cur_match = {8'd0, data};
        end
        if (is_last) begin
            pending_codes.push_back('{code: cur_match, item_last: 1'b1, stream_end: 1'b1});
            stream_restart();
        end
    endfunction

    // Valid stays up across back-to-back beats; it only drops for a gap.
    task automatic send_byte(input logic [7:0] data, input logic is_last);
        int gap;
        gap = $urandom_range(0, in_hold_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_data_byte   <= data;
        i_stream_last <= is_last;
        do @(posedge i_clk); while (!o_ready);
        lzw_encode_byte(data, is_last);
    endtask

    task automatic send_stream(input logic [7:0] bytes [$]);
        foreach (bytes[k])
            send_byte(bytes[k], k == bytes.size() - 1);
    endtask

    task automatic test_directed();
        in_hold_max  = 3;
        out_hold_max = 3;
        send_stream('{8'h00});
        send_stream('{8'hFF});
        // miss on the closing byte: old match, then the byte itself
        send_stream('{8'h41, 8'h42});
        // closing byte hits an entry learned earlier in the stream
        send_stream('{8'h41, 8'h42, 8'h41, 8'h42});
        send_stream('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF});
        send_stream('{8'h55, 8'hAA, 8'h55, 8'hAA});
    endtask

    task automatic test_random_streams(input int n_bytes);
        logic [7:0] stream [$];
        logic [7:0] base;
        int         sent;
        int         len;
        int         kind;
        sent = 0;
        while (sent < n_bytes) begin
            case ($urandom_range(0, 3))
                0: begin in_hold_max = 0; out_hold_max = 0; end
                1: begin in_hold_max = 5; out_hold_max = 0; end
                2: begin in_hold_max = 0; out_hold_max = 5; end
                default: begin in_hold_max = 5; out_hold_max = 5; end
            endcase
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 160)
                                               : $urandom_range(1, 30);
            kind = $urandom_range(0, 2);
            base = 8'($urandom);
            stream.delete();
            // narrow alphabets build long matches and deep codes
            repeat (len) begin
                case (kind)
                    0: stream.push_back(8'($urandom));
                    1: stream.push_back(base ^ 8'($urandom_range(0, 1)));
                    default: stream.push_back(base + 8'($urandom_range(0, 3)));
                endcase
            end
            send_stream(stream);
            sent += len;
        end
    endtask

    initial begin : result_check
        t_res want;
        int   stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = $urandom_range(0, out_hold_max);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
            if (pending_codes.size() == 0) begin
                report_error($sformatf("unexpected beat, code %0d", o_code));
            end else begin
                want = pending_codes.pop_front();
                if (o_code !== want.code)
                    report_error($sformatf("code got %0d want %0d", o_code, want.code));
                if (o_item_last !== want.item_last)
                    report_error($sformatf("item_last got %b want %b (code %0d)",
                                           o_item_last, want.item_last, want.code));
                if (o_stream_end !== want.stream_end)
                    report_error($sformatf("stream_end got %b want %b (code %0d)",
                                           o_stream_end, want.stream_end, want.code));
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        stream_restart();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_streams(1300);

        i_valid <= 1'b0;
        while (pending_codes.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
